// ===== src/rcm_pkg.sv =====
// rcm_pkg: shared types and constants for the rssi channel monitor
// no dependencies; imported by rcm_noise, rcm_util and rssi_channel_monitor
package rcm_pkg;

  // noise ring depth is a power of two so the mean is a shift
  localparam int NOISE_LOG2  = 7;
  localparam int NOISE_DEPTH = 1 << NOISE_LOG2;

  localparam int RSSI_W     = 10;
  localparam int COUNT_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [RSSI_W-1:0] FLOOR_RESET = -10'sd292;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECAL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVOID  = 2'd3;

  // configuration reset values
  localparam logic [5:0]         MARGIN_RESET = 6'd11;
  localparam logic signed [8:0]  LIMIT_RESET  = -9'sd83;
  localparam logic [15:0]        RECAL_RESET  = 16'd2500;
  localparam logic               AVOID_RESET  = 1'b1;

  typedef struct packed {
    logic [5:0]        interference_margin_db;
    logic signed [8:0] recal_limit_dbm;
    logic [15:0]       recal_time_ms;
    logic              intf_blocks;
  } cfg_t;

  typedef struct packed {
    logic signed [RSSI_W-1:0] rssi_dbm;
    logic                     carrier_sense;
    logic                     receiving;
    logic [31:0]              now_ms;
  } in_t;

  typedef struct packed {
    logic signed [RSSI_W-1:0] noise_floor_dbm;
    logic                     interference;
    logic                     calibrated;
    logic                     medium_free;
    logic [COUNT_W-1:0]       carrier_count;
    logic                     util_update;
  } out_t;

  // noise tracker status after the current request
  typedef struct packed {
    logic signed [RSSI_W-1:0] floor_dbm;
    logic                     interference;
    logic                     calibrated;
  } nf_stat_t;

  // carrier window status after the current request
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               update;
  } util_stat_t;

endpackage

// ===== src/rcm_ram.sv =====
// rcm_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rcm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/rcm_noise.sv =====
// rcm_noise: noise floor ring, interference flag and recalibration timer
// depends on rcm_pkg and rcm_ram
module rcm_noise (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  rcm_pkg::in_t      item,
  input  rcm_pkg::cfg_t     cfg,
  output rcm_pkg::nf_stat_t stat
);
  import rcm_pkg::*;

  localparam int SW = RSSI_W + NOISE_LOG2;

  logic [NOISE_LOG2-1:0]    idx_r, idx_nxt;
  logic                     full_r, full_nxt;
  logic signed [SW-1:0]     sum_r, sum_nxt;
  logic                     valid_r, valid_nxt;
  logic signed [RSSI_W-1:0] floor_r, floor_nxt;
  logic                     intf_r, intf_nxt;
  logic                     persist_r, persist_nxt;
  logic [31:0]              start_r, start_nxt;

  logic [RSSI_W-1:0]        ring_q;
  logic                     ring_we;
  logic signed [RSSI_W:0]   thresh;
  logic signed [RSSI_W:0]   rssi_x;
  logic signed [RSSI_W-1:0] limit_x;
  logic [31:0]              elapsed;
  logic signed [SW-1:0]     old_x;
  logic signed [SW-1:0]     bias;
  logic signed [SW-1:0]     biased;
  logic                     quiet;

  // read address follows the next index so the entry is ready once that index is current
  rcm_ram #(
    .WIDTH (RSSI_W),
    .DEPTH (NOISE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (idx_r),
    .wr_data (item.rssi_dbm),
    .rd_addr (idx_nxt),
    .rd_data (ring_q)
  );

  always_comb begin
    thresh  = (RSSI_W+1)'(floor_r) + $signed({5'd0, cfg.interference_margin_db});
    rssi_x  = (RSSI_W+1)'(item.rssi_dbm);
    limit_x = RSSI_W'(cfg.recal_limit_dbm);
    elapsed = item.now_ms - start_r;
    // entries not yet written since reset read as zero
    old_x   = full_r ? SW'($signed(ring_q)) : '0;

    idx_nxt     = idx_r;
    full_nxt    = full_r;
    sum_nxt     = sum_r;
    valid_nxt   = valid_r;
    floor_nxt   = floor_r;
    intf_nxt    = intf_r;
    persist_nxt = persist_r;
    start_nxt   = start_r;
    ring_we     = 1'b0;
    quiet       = 1'b0;
    bias        = '0;
    biased      = '0;

    if (step_en) begin
      intf_nxt = valid_r && !item.carrier_sense && (rssi_x > thresh);

      if (intf_nxt && (item.rssi_dbm < limit_x)) begin
        if (!persist_r) begin
          persist_nxt = 1'b1;
          start_nxt   = item.now_ms;
        end else if (elapsed >= {16'd0, cfg.recal_time_ms}) begin
          valid_nxt   = 1'b0;
          persist_nxt = 1'b0;
        end
      end else begin
        persist_nxt = 1'b0;
      end

      quiet = !item.carrier_sense && (!valid_nxt || (rssi_x < thresh));

      if (quiet) begin
        ring_we = 1'b1;
        sum_nxt = sum_r + SW'(item.rssi_dbm) - old_x;
        idx_nxt = idx_r + NOISE_LOG2'(1);
        if (idx_nxt == '0) begin
          full_nxt  = 1'b1;
          valid_nxt = 1'b1;
        end
        // mean truncated toward zero
        bias   = sum_nxt[SW-1] ? SW'(NOISE_DEPTH - 1) : '0;
        biased = sum_nxt + bias;
        if (valid_nxt) begin
          floor_nxt = biased[SW-1:NOISE_LOG2];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      full_r    <= 1'b0;
      sum_r     <= '0;
      valid_r   <= 1'b0;
      floor_r   <= FLOOR_RESET;
      intf_r    <= 1'b0;
      persist_r <= 1'b0;
      start_r   <= '0;
    end else begin
      idx_r     <= idx_nxt;
      full_r    <= full_nxt;
      sum_r     <= sum_nxt;
      valid_r   <= valid_nxt;
      floor_r   <= floor_nxt;
      intf_r    <= intf_nxt;
      persist_r <= persist_nxt;
      start_r   <= start_nxt;
    end
  end

  assign stat.floor_dbm    = floor_nxt;
  assign stat.interference = intf_nxt;
  assign stat.calibrated   = valid_nxt;

endmodule

// ===== src/rcm_util.sv =====
// rcm_util: carrier-detect window, running carrier count and interval timer
// depends on rcm_pkg and rcm_ram
module rcm_util #(
  parameter int UTIL_WINDOW   = 2500,
  parameter int UTIL_INTERVAL = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                carrier,
  output rcm_pkg::util_stat_t stat
);
  import rcm_pkg::*;

  localparam int CIW = $clog2(UTIL_WINDOW);
  localparam int CTW = $clog2(UTIL_WINDOW + 1);
  localparam int IW  = (UTIL_INTERVAL > 1) ? $clog2(UTIL_INTERVAL) : 1;
  localparam int CW  = (CTW > COUNT_W) ? CTW : COUNT_W;

  logic [CIW-1:0] c_r, c_nxt;
  logic           full_r, full_nxt;
  logic [CTW-1:0] total_r, total_nxt;
  logic [IW-1:0]  ivl_r, ivl_nxt;

  logic           win_q;
  logic           old_bit;
  logic [IW:0]    ivl_inc;
  logic           upd;
  logic [CW-1:0]  cnt_ext;

  rcm_ram #(
    .WIDTH (1),
    .DEPTH (UTIL_WINDOW)
  ) u_window (
    .clk     (clk),
    .wr_en   (step_en),
    .wr_addr (c_r),
    .wr_data (carrier),
    .rd_addr (c_nxt),
    .rd_data (win_q)
  );

  always_comb begin
    old_bit   = full_r & win_q;
    ivl_inc   = {1'b0, ivl_r} + {{IW{1'b0}}, 1'b1};
    c_nxt     = c_r;
    full_nxt  = full_r;
    total_nxt = total_r;
    ivl_nxt   = ivl_r;
    upd       = 1'b0;

    if (step_en) begin
      c_nxt     = (c_r == CIW'(UTIL_WINDOW - 1)) ? '0 : c_r + CIW'(1);
      total_nxt = total_r - CTW'(old_bit) + CTW'(carrier);
      if (c_nxt == '0) begin
        full_nxt = 1'b1;
      end
      // ivl tracks the window index modulo the report interval
      if ((c_nxt == '0) || (ivl_inc == (IW+1)'(UTIL_INTERVAL))) begin
        ivl_nxt = '0;
      end else begin
        ivl_nxt = ivl_inc[IW-1:0];
      end
      upd = (ivl_nxt == '0);
    end

    cnt_ext = CW'(total_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r     <= '0;
      full_r  <= 1'b0;
      total_r <= '0;
      ivl_r   <= '0;
    end else begin
      c_r     <= c_nxt;
      full_r  <= full_nxt;
      total_r <= total_nxt;
      ivl_r   <= ivl_nxt;
    end
  end

  assign stat.update = upd;
  assign stat.count  = !upd ? '0
                     : (cnt_ext > CW'(4095)) ? {COUNT_W{1'b1}} : cnt_ext[COUNT_W-1:0];

endmodule

// ===== src/rssi_channel_monitor.sv =====
// rssi_channel_monitor: top level of the noise floor and interference monitor
// depends on rcm_pkg, rcm_noise, rcm_util and rcm_ram
//
//   port group   direction  handshake          payload
//   in_*         request    in_valid/in_stall  rcm_pkg::in_t  (rssi, dcd, rx, time)
//   out_*        result     out_valid/out_stall rcm_pkg::out_t (floor, flags, count)
//   cfg_*        write      cfg_we             cfg_index, cfg_wdata
//
// one request per clock sustained while out_stall is low; each taken request
// passes the input register, then the result register
// the two rings sit in registered-read rams whose read address is the next
// write index, so the old entry is ready when the next request arrives
// reset is synchronous; ring contents are masked by a wrapped flag until the
// first full lap, so no clearing pass is needed and requests are taken at once
// a stalled result holds the result register; the input register then fills
// and in_stall rises until the result is taken
module rssi_channel_monitor #(
  parameter int UTIL_WINDOW   = 2500,
  parameter int UTIL_INTERVAL = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  rcm_pkg::in_t                    in_data,

  output logic                            out_valid,
  input  logic                            out_stall,
  output rcm_pkg::out_t                   out_data,

  input  logic                            cfg_we,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rcm_pkg::*;

  // configuration registers
  cfg_t       cfg_r;

  // input stage
  in_t        in_r;
  logic       in_valid_r;

  // result stage
  out_t       out_r;
  out_t       out_nxt;
  logic       out_valid_r;

  logic       advance;     // result register can take a new result
  logic       go;          // request in the input stage is processed this cycle
  logic       step_en;     // processed request changes state
  nf_stat_t   nf_stat;
  util_stat_t util_stat;

  assign advance  = !out_valid_r || !out_stall;
  assign go       = in_valid_r && advance;
  assign step_en  = go && in_r.receiving;
  assign in_stall = in_valid_r && !advance;

  // register writes, taken whenever the enable is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interference_margin_db <= MARGIN_RESET;
      cfg_r.recal_limit_dbm        <= LIMIT_RESET;
      cfg_r.recal_time_ms          <= RECAL_RESET;
      cfg_r.intf_blocks            <= AVOID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MARGIN: cfg_r.interference_margin_db <= cfg_wdata[5:0];
        REG_LIMIT:  cfg_r.recal_limit_dbm        <= cfg_wdata[8:0];
        REG_RECAL:  cfg_r.recal_time_ms          <= cfg_wdata[15:0];
        REG_AVOID:  cfg_r.intf_blocks            <= cfg_wdata[0];
      endcase
    end
  end

  // noise floor, interference and recalibration
  rcm_noise u_noise (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_r),
    .cfg     (cfg_r),
    .stat    (nf_stat)
  );

  // carrier window and periodic count
  rcm_util #(
    .UTIL_WINDOW   (UTIL_WINDOW),
    .UTIL_INTERVAL (UTIL_INTERVAL)
  ) u_util (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .carrier (in_r.carrier_sense),
    .stat    (util_stat)
  );

  // result assembly; a request outside receive mode reports held noise state and a zero count
  always_comb begin
    out_nxt.noise_floor_dbm = nf_stat.floor_dbm;
    out_nxt.interference    = nf_stat.interference;
    out_nxt.calibrated      = nf_stat.calibrated;
    out_nxt.medium_free     = !(cfg_r.intf_blocks && nf_stat.interference)
                              && !in_r.carrier_sense;
    out_nxt.carrier_count   = util_stat.count;
    out_nxt.util_update     = util_stat.update;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (go) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a waiting request moves into the result stage once the result is taken
  a_waiting_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && in_valid_r) |=> out_valid)
    else $error("waiting request not moved to result stage");

  // a new result always comes from a request held in the input stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid_r))
    else $error("result appeared without a request");

  // stale counts read as zero
  a_stale_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.util_update) |-> (out_data.carrier_count == '0))
    else $error("carrier count nonzero without update");

  // an accepted request is always held in the input stage next cycle
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_valid_r)
    else $error("accepted request lost");

  // medium is never free while a carrier was reported
  a_busy_on_carrier: assert property (@(posedge clk) disable iff (!rst_n)
    (go && in_r.carrier_sense) |=> !out_data.medium_free)
    else $error("medium reported free with carrier present");

endmodule
